### rtl/ssd_box_decode_filter_core_defines.svh
// ----------------------------------------------------------------------------
// SSD box decode filter: shared assertion macros
// Property macros used by the checker that watches the core's ports.
// ----------------------------------------------------------------------------
`ifndef SSD_BOX_DECODE_FILTER_CORE_DEFINES_SVH
`define SSD_BOX_DECODE_FILTER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBDF_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("sbdf: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SBDF_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("sbdf: next-cycle check failed");

`endif

### rtl/sbdf_pkg.sv
// ----------------------------------------------------------------------------
// SSD box decode filter: package
// Constants, word types and the exponent table shared by the core's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sbdf_pkg;

  localparam int unsigned NumAnchors  = 8732;
  localparam int unsigned NumClasses  = 21;

  localparam int unsigned InDataW     = 168;
  localparam int unsigned OutDataW    = 104;

  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam logic [CfgAddrW-3:0] RegThresholdIdx = 1'b0;
  localparam logic [15:0] ThresholdReset = 16'd32768;

  localparam logic [13:0] CenterVarQ16 = 14'd6554;
  localparam logic [13:0] SizeVarQ16   = 14'd13107;
  localparam logic [4:0]  ExpTableMid  = 5'd13;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef logic [18:0] exp_val_t;

  typedef struct packed {
    logic [7:0]  class_label;
    logic [15:0] anchor_index;
    logic [15:0] score;
  } meta_t;

  typedef struct packed {
    logic signed [15:0] delta_c;
    logic signed [15:0] delta_s;
    logic signed [15:0] prior_c;
    logic [14:0]        prior_s;
  } axis_in_t;

  // ax[0] is the x axis, ax[1] the y axis.
  typedef struct packed {
    meta_t          meta;
    axis_in_t [1:0] ax;
  } item_t;

  // round(65536 * exp(j/8)) for j = -13..13.
  function automatic exp_val_t exp_table(input logic [4:0] idx);
    exp_val_t v;
    case (idx)
      5'd0:    v = 19'd12905;
      5'd1:    v = 19'd14623;
      5'd2:    v = 19'd16570;
      5'd3:    v = 19'd18776;
      5'd4:    v = 19'd21276;
      5'd5:    v = 19'd24109;
      5'd6:    v = 19'd27319;
      5'd7:    v = 19'd30957;
      5'd8:    v = 19'd35079;
      5'd9:    v = 19'd39750;
      5'd10:   v = 19'd45042;
      5'd11:   v = 19'd51039;
      5'd12:   v = 19'd57835;
      5'd13:   v = 19'd65536;
      5'd14:   v = 19'd74262;
      5'd15:   v = 19'd84150;
      5'd16:   v = 19'd95354;
      5'd17:   v = 19'd108051;
      5'd18:   v = 19'd122437;
      5'd19:   v = 19'd138740;
      5'd20:   v = 19'd157213;
      5'd21:   v = 19'd178145;
      5'd22:   v = 19'd201865;
      5'd23:   v = 19'd228743;
      5'd24:   v = 19'd259200;
      5'd25:   v = 19'd293712;
      5'd26:   v = 19'd332819;
      default: v = 19'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/sbdf_front.sv
// ----------------------------------------------------------------------------
// SSD box decode filter: front end
// Accepts input words, unpacks them and drops background, out-of-range and
// low-score anchors. Passing items are offered to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sbdf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [sbdf_pkg::InDataW-1:0] in_tdata,
  input  logic [15:0]                  score_threshold,
  output logic                         push_valid,
  output sbdf_pkg::item_t              push_item,
  input  logic                         push_ready
);
  import sbdf_pkg::*;

  logic  f_valid_r, f_valid_nxt;
  logic  f_pass_r, f_pass_nxt;
  item_t f_item_r, f_item_nxt;
  logic  f_leave;
  logic  load;

  always_comb begin
    f_item_nxt.meta.class_label  = in_tdata[7:0];
    f_item_nxt.meta.anchor_index = in_tdata[23:8];
    f_item_nxt.meta.score        = in_tdata[39:24];
    f_item_nxt.ax[0].delta_c     = in_tdata[55:40];
    f_item_nxt.ax[1].delta_c     = in_tdata[71:56];
    f_item_nxt.ax[0].delta_s     = in_tdata[87:72];
    f_item_nxt.ax[1].delta_s     = in_tdata[103:88];
    f_item_nxt.ax[0].prior_c     = in_tdata[119:104];
    f_item_nxt.ax[1].prior_c     = in_tdata[135:120];
    f_item_nxt.ax[0].prior_s     = in_tdata[150:136];
    f_item_nxt.ax[1].prior_s     = in_tdata[165:151];
  end

  assign f_pass_nxt = (in_tdata[7:0] != 8'd0) &&
                      ({1'b0, in_tdata[7:0]} < 9'(NumClasses)) &&
                      ({1'b0, in_tdata[23:8]} < 17'(NumAnchors)) &&
                      (in_tdata[39:24] >= score_threshold);

  assign f_leave     = f_valid_r && (!f_pass_r || push_ready);
  assign in_tready   = !f_valid_r || f_leave;
  assign load        = in_tready && in_tvalid;
  assign f_valid_nxt = in_tready ? in_tvalid : f_valid_r;

  assign push_valid = f_valid_r && f_pass_r;
  assign push_item  = f_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f_item_r <= f_item_nxt;
      f_pass_r <= f_pass_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/sbdf_queue.sv
// ----------------------------------------------------------------------------
// SSD box decode filter: item queue
// Short first-in first-out queue between the front end and the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module sbdf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  sbdf_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output sbdf_pkg::item_t pop_item
);
  import sbdf_pkg::*;

  item_t                mem_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QueuePtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QueuePtrW:0]   count_r, count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = count_r != (QueuePtrW + 1)'(QueueDepth);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop_valid && pop_ready;

  assign wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### rtl/sbdf_back.sv
// ----------------------------------------------------------------------------
// SSD box decode filter: box decoder
// Seven-stage pipeline that decodes the center and size of both axes,
// evaluates the exponent by table and interpolation, and forms saturated
// corners in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbdf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sbdf_pkg::item_t               in_item,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sbdf_pkg::OutDataW-1:0] out_tdata
);
  import sbdf_pkg::*;

  localparam int unsigned NumStages = 6;

  typedef struct packed {
    logic signed [15:0] pc;
    logic [14:0]        ps;
    logic signed [31:0] mc;
    logic signed [31:0] ma;
  } sa_ax_t;
  typedef struct packed {
    meta_t        meta;
    sa_ax_t [1:0] ax;
  } sa_t;

  typedef struct packed {
    logic signed [15:0] pc;
    logic [14:0]        ps;
    logic signed [47:0] mcc;
    logic signed [17:0] a;
  } sb_ax_t;
  typedef struct packed {
    meta_t        meta;
    sb_ax_t [1:0] ax;
  } sb_t;

  typedef struct packed {
    logic [14:0]        ps;
    logic signed [17:0] center;
    exp_val_t           lo;
    logic [15:0]        dif;
    logic [12:0]        f;
  } sc_ax_t;
  typedef struct packed {
    meta_t        meta;
    sc_ax_t [1:0] ax;
  } sc_t;

  typedef struct packed {
    logic [14:0]        ps;
    logic signed [17:0] center;
    exp_val_t           lo;
    logic [28:0]        prod;
  } sd_ax_t;
  typedef struct packed {
    meta_t        meta;
    sd_ax_t [1:0] ax;
  } sd_t;

  typedef struct packed {
    logic [14:0]        ps;
    logic signed [17:0] center;
    exp_val_t           e;
  } se_ax_t;
  typedef struct packed {
    meta_t        meta;
    se_ax_t [1:0] ax;
  } se_t;

  typedef struct packed {
    logic signed [17:0] center;
    logic [33:0]        h;
  } sf_ax_t;
  typedef struct packed {
    meta_t        meta;
    sf_ax_t [1:0] ax;
  } sf_t;

  typedef struct packed {
    meta_t                    meta;
    logic [1:0][15:0]         c_lo;
    logic [1:0][15:0]         c_hi;
  } so_t;

  function automatic logic [15:0] sat16(input logic signed [19:0] v);
    logic [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic [NumStages-1:0] v_r, v_nxt;
  logic [NumStages-1:0] go;
  logic                 out_v_r, out_v_nxt;
  logic                 go_out;

  sa_t sa_r, sa_nxt;
  sb_t sb_r, sb_nxt;
  sc_t sc_r, sc_nxt;
  sd_t sd_r, sd_nxt;
  se_t se_r, se_nxt;
  sf_t sf_r, sf_nxt;
  so_t so_r, so_nxt;

  // Stall control: a stage loads when it is empty or its content moves on.
  always_comb begin
    go_out = !out_v_r || out_tready;
    go[NumStages-1] = !v_r[NumStages-1] || go_out;
    for (int i = NumStages - 2; i >= 0; i--) begin
      go[i] = !v_r[i] || go[i+1];
    end
    v_nxt[0] = go[0] ? in_valid : v_r[0];
    for (int i = 1; i < NumStages; i++) begin
      v_nxt[i] = go[i] ? v_r[i-1] : v_r[i];
    end
    out_v_nxt = go_out ? v_r[NumStages-1] : out_v_r;
  end

  assign in_ready = go[0];

  always_comb begin
    sa_nxt.meta = in_item.meta;
    for (int i = 0; i < 2; i++) begin
      sa_nxt.ax[i].pc = in_item.ax[i].prior_c;
      sa_nxt.ax[i].ps = in_item.ax[i].prior_s;
      sa_nxt.ax[i].mc = 32'(in_item.ax[i].delta_c) *
                        32'($signed({1'b0, in_item.ax[i].prior_s}));
      sa_nxt.ax[i].ma = 32'(in_item.ax[i].delta_s) *
                        32'($signed({1'b0, SizeVarQ16}));
    end
  end

  always_comb begin
    sb_nxt.meta = sa_r.meta;
    for (int i = 0; i < 2; i++) begin
      sb_nxt.ax[i].pc  = sa_r.ax[i].pc;
      sb_nxt.ax[i].ps  = sa_r.ax[i].ps;
      sb_nxt.ax[i].mcc = 48'(sa_r.ax[i].mc) * 48'($signed({1'b0, CenterVarQ16}));
      sb_nxt.ax[i].a   = 18'((sa_r.ax[i].ma + 32'sd2048) >>> 12);
    end
  end

  // The top five bits of the exponent are floor(a / 8192); the input range
  // keeps the table index within 0..25.
  always_comb begin
    logic [4:0] idx;
    exp_val_t   hi;
    sc_nxt.meta = sb_r.meta;
    for (int i = 0; i < 2; i++) begin
      idx = sb_r.ax[i].a[17:13] + ExpTableMid;
      hi  = exp_table(idx + 5'd1);
      sc_nxt.ax[i].ps     = sb_r.ax[i].ps;
      sc_nxt.ax[i].center = 18'(sb_r.ax[i].pc) +
                            18'((sb_r.ax[i].mcc + 48'sd134217728) >>> 28);
      sc_nxt.ax[i].lo     = exp_table(idx);
      sc_nxt.ax[i].dif    = 16'(hi - exp_table(idx));
      sc_nxt.ax[i].f      = sb_r.ax[i].a[12:0];
    end
  end

  always_comb begin
    sd_nxt.meta = sc_r.meta;
    for (int i = 0; i < 2; i++) begin
      sd_nxt.ax[i].ps     = sc_r.ax[i].ps;
      sd_nxt.ax[i].center = sc_r.ax[i].center;
      sd_nxt.ax[i].lo     = sc_r.ax[i].lo;
      sd_nxt.ax[i].prod   = 29'(sc_r.ax[i].dif) * 29'(sc_r.ax[i].f);
    end
  end

  always_comb begin
    se_nxt.meta = sd_r.meta;
    for (int i = 0; i < 2; i++) begin
      se_nxt.ax[i].ps     = sd_r.ax[i].ps;
      se_nxt.ax[i].center = sd_r.ax[i].center;
      se_nxt.ax[i].e      = sd_r.ax[i].lo +
                            19'((30'(sd_r.ax[i].prod) + 30'd4096) >> 13);
    end
  end

  always_comb begin
    sf_nxt.meta = se_r.meta;
    for (int i = 0; i < 2; i++) begin
      sf_nxt.ax[i].center = se_r.ax[i].center;
      sf_nxt.ax[i].h      = 34'(se_r.ax[i].e) * 34'(se_r.ax[i].ps);
    end
  end

  always_comb begin
    logic [16:0]        half;
    logic signed [19:0] half_s;
    so_nxt.meta = sf_r.meta;
    for (int i = 0; i < 2; i++) begin
      half   = 17'((35'(sf_r.ax[i].h) + 35'd65536) >> 17);
      half_s = $signed({3'b000, half});
      so_nxt.c_lo[i] = sat16(20'(sf_r.ax[i].center) - half_s);
      so_nxt.c_hi[i] = sat16(20'(sf_r.ax[i].center) + half_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else begin
      v_r     <= v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      sa_r <= sa_nxt;
    end
    if (go[1]) begin
      sb_r <= sb_nxt;
    end
    if (go[2]) begin
      sc_r <= sc_nxt;
    end
    if (go[3]) begin
      sd_r <= sd_nxt;
    end
    if (go[4]) begin
      se_r <= se_nxt;
    end
    if (go[5]) begin
      sf_r <= sf_nxt;
    end
    if (go_out) begin
      so_r <= so_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {so_r.c_hi[1], so_r.c_hi[0], so_r.c_lo[1], so_r.c_lo[0],
                       so_r.meta.score, so_r.meta.anchor_index,
                       so_r.meta.class_label};

endmodule

`default_nettype wire

### rtl/ssd_box_decode_filter_core.sv
// ----------------------------------------------------------------------------
// SSD box decode filter core
// Filters one class score per anchor against the score threshold and decodes
// the passing anchor's box into saturated corners.
//
//   Channel  Dir  Signals                        Word
//   in_      in   in_tvalid/in_tready/in_tdata   one anchor score and box inputs
//   out_     out  out_tvalid/out_tready/out_tdata one detection
//   cfg_     in   APB psel/penable/pwrite/...    score threshold register
//
// One word is accepted per cycle while in_tready is high; a rejected word is
// dropped in the front register. The decoder pipeline has two multiply
// stages, the exponent table stage, the interpolation multiply and add, the
// size multiply and the corner output register. A four-entry queue parts the
// filter from the decoder, so a stall at the output first fills the pipeline
// and the queue before in_tready drops. Reset is synchronous and clears all
// valid state.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_box_decode_filter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // Fields from bit 0: class_label[8], anchor_index[16], score[16],
  // delta_cx, delta_cy, delta_w, delta_h, prior_cx, prior_cy [16 each],
  // prior_w[15], prior_h[15], two zero pad bits.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sbdf_pkg::InDataW-1:0]  in_tdata,
  // Fields from bit 0: out_class[8], out_anchor[16], out_score[16],
  // box_x1, box_y1, box_x2, box_y2 [16 each].
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sbdf_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [sbdf_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [sbdf_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [sbdf_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import sbdf_pkg::*;

  logic [15:0] thr_r, thr_nxt;
  logic        cfg_wr;
  logic        q_push_valid;
  logic        q_push_ready;
  item_t       q_push_item;
  logic        q_pop_valid;
  logic        q_pop_ready;
  item_t       q_pop_item;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[CfgAddrW-1:2] == RegThresholdIdx);
  assign thr_nxt    = cfg_wr ? cfg_pwdata[15:0] : thr_r;
  assign cfg_prdata = (cfg_paddr[CfgAddrW-1:2] == RegThresholdIdx) ?
                      {{(CfgDataW - 16){1'b0}}, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThresholdReset;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  sbdf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .score_threshold (thr_r),
    .push_valid      (q_push_valid),
    .push_item       (q_push_item),
    .push_ready      (q_push_ready)
  );

  sbdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  sbdf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (q_pop_valid),
    .in_ready   (q_pop_ready),
    .in_item    (q_pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

### rtl/sbdf_checker.sv
// ----------------------------------------------------------------------------
// SSD box decode filter: port checker
// Watches the core's result port and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ssd_box_decode_filter_core_defines.svh"

module sbdf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [sbdf_pkg::OutDataW-1:0] out_tdata
);
  import sbdf_pkg::*;

  `SBDF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SBDF_ASSERT_NOW(a_x_order, clk, rst_n, out_tvalid, $signed(out_tdata[55:40]) <= $signed(out_tdata[87:72]))
  `SBDF_ASSERT_NOW(a_y_order, clk, rst_n, out_tvalid, $signed(out_tdata[71:56]) <= $signed(out_tdata[103:88]))
  `SBDF_ASSERT_NOW(a_ids, clk, rst_n, out_tvalid, out_tdata[7:0] != 8'd0 && {1'b0, out_tdata[7:0]} < 9'(NumClasses) && {1'b0, out_tdata[23:8]} < 17'(NumAnchors))

endmodule

bind ssd_box_decode_filter_core sbdf_checker u_sbdf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
